[rtl/spmp_pkg.sv]
// spmp_pkg: shared types and constants for the slot permutation move planner
// no dependencies; used by spmp_lane, spmp_merge and the top level
package spmp_pkg;

  localparam int unsigned SLOT_COUNT = 4;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned LABEL_W    = 3;
  localparam int unsigned MOVE_W     = 3;

  localparam logic [MOVE_W-1:0] MOVE_LIMIT = 3'd4;

  localparam logic [1:0] ST_MOVE    = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic                  in_place;
    logic                  range_err;
    logic [SLOT_COUNT-1:0] hit;
  } lane_out_t;

  typedef struct packed {
    logic             range_err;
    logic             missing;
    logic             found;
    logic [IDX_W-1:0] wrong_label;
    logic [IDX_W-1:0] wrong_pos;
    logic [IDX_W-1:0] src;
    logic [IDX_W-1:0] empty;
  } plan_t;

endpackage

[rtl/slot_permutation_move_planner_unit.sv]
// slot_permutation_move_planner_unit: top level, capture register, planner fsm, output register
// depends on spmp_pkg, spmp_lane and spmp_merge
// first result: written to the output register from S_CHECK on an error, otherwise from S_PLAN
// throughput: one result per cycle while out_stall is low; a new input is taken only once the
// planner has returned to idle after the final result, the planner emitting one move per cycle
// reset: synchronous active-low rst_n returns the fsm to idle and empties the output register
module slot_permutation_move_planner_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_slot0_label,
  input  logic [2:0] in_slot1_label,
  input  logic [2:0] in_slot2_label,
  input  logic [2:0] in_slot3_label,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_move_from,
  output logic [1:0] out_move_to,
  output logic [1:0] out_status,
  output logic       out_last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_PLAN,
    S_SECOND
  } state_t;

  localparam int unsigned N = spmp_pkg::SLOT_COUNT;
  localparam int unsigned W = spmp_pkg::IDX_W;

  state_t state_r, state_nxt;
  logic [N-1:0][spmp_pkg::LABEL_W-1:0] lab_r, lab_nxt;
  logic [spmp_pkg::MOVE_W-1:0] n_r, n_nxt, n_inc;
  logic [W-1:0] sec_from_r, sec_from_nxt, sec_to_r, sec_to_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] from_r, from_nxt, to_r, to_nxt, status_r, status_nxt;
  logic       last_r, last_nxt;
  logic       out_free;

  spmp_pkg::lane_out_t [N-1:0] lanes;
  spmp_pkg::plan_t             plan;

  for (genvar g = 0; g < N; g++) begin : g_lane
    spmp_lane #(.SLOT(g)) u_lane (
      .label    (lab_r[g]),
      .lane_out (lanes[g])
    );
  end

  spmp_merge u_merge (
    .lanes (lanes),
    .plan  (plan)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign n_inc    = n_r + 3'd1;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    lab_nxt       = lab_r;
    n_nxt         = n_r;
    sec_from_nxt  = sec_from_r;
    sec_to_nxt    = sec_to_r;
    out_valid_nxt = out_valid_r && out_stall;
    from_nxt      = from_r;
    to_nxt        = to_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          lab_nxt[0] = in_slot0_label;
          lab_nxt[1] = in_slot1_label;
          lab_nxt[2] = in_slot2_label;
          lab_nxt[3] = in_slot3_label;
          n_nxt      = '0;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (out_free) begin
          if (plan.range_err || plan.missing) begin
            out_valid_nxt = 1'b1;
            from_nxt      = '0;
            to_nxt        = '0;
            status_nxt    = plan.range_err ? spmp_pkg::ST_RANGE : spmp_pkg::ST_MISSING;
            last_nxt      = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_PLAN;
          end
        end
      end
      S_PLAN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (n_r == spmp_pkg::MOVE_LIMIT || !plan.found) begin
            from_nxt   = '0;
            to_nxt     = '0;
            status_nxt = spmp_pkg::ST_DONE;
            last_nxt   = 1'b1;
            state_nxt  = S_IDLE;
          end else if (plan.wrong_label == '0) begin
            from_nxt                = plan.src;
            to_nxt                  = plan.wrong_pos;
            status_nxt              = spmp_pkg::ST_MOVE;
            last_nxt                = 1'b0;
            lab_nxt[plan.src]       = lab_r[plan.wrong_pos];
            lab_nxt[plan.wrong_pos] = lab_r[plan.src];
            n_nxt                   = n_inc;
          end else begin
            from_nxt                  = plan.wrong_label;
            to_nxt                    = plan.empty;
            status_nxt                = spmp_pkg::ST_MOVE;
            last_nxt                  = 1'b0;
            lab_nxt[plan.wrong_label] = lab_r[plan.empty];
            lab_nxt[plan.empty]       = lab_r[plan.wrong_label];
            n_nxt                     = n_inc;
            sec_from_nxt              = plan.wrong_pos;
            sec_to_nxt                = plan.wrong_label;
            if (n_inc < spmp_pkg::MOVE_LIMIT) begin
              state_nxt = S_SECOND;
            end
          end
        end
      end
      S_SECOND: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          from_nxt            = sec_from_r;
          to_nxt              = sec_to_r;
          status_nxt          = spmp_pkg::ST_MOVE;
          last_nxt            = 1'b0;
          lab_nxt[sec_from_r] = lab_r[sec_to_r];
          lab_nxt[sec_to_r]   = lab_r[sec_from_r];
          n_nxt               = n_inc;
          state_nxt           = S_PLAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
    end
    lab_r      <= lab_nxt;
    sec_from_r <= sec_from_nxt;
    sec_to_r   <= sec_to_nxt;
    from_r     <= from_nxt;
    to_r       <= to_nxt;
    status_r   <= status_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_move_from = from_r;
  assign out_move_to   = to_r;
  assign out_status    = status_r;
  assign out_last      = last_r;

`ifndef SYNTH
  a_last_iff_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (last_r == (status_r != spmp_pkg::ST_MOVE)))
    else $error("last flag does not match status");

  a_move_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == spmp_pkg::ST_MOVE |-> from_r != to_r)
    else $error("move with equal source and destination");

  a_move_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= spmp_pkg::MOVE_LIMIT)
    else $error("move count beyond limit");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_CHECK)
    else $error("planner not checking after input transfer");
`endif

endmodule

[rtl/spmp_lane.sv]
// spmp_lane: per-slot compare lane, range check, label decode and home test
// depends on spmp_pkg
module spmp_lane #(
  parameter int unsigned SLOT = 0
) (
  input  logic [spmp_pkg::LABEL_W-1:0] label,
  output spmp_pkg::lane_out_t          lane_out
);

  always_comb begin
    lane_out.range_err = label[spmp_pkg::LABEL_W-1];
    lane_out.in_place  = (label == spmp_pkg::LABEL_W'(SLOT));
    lane_out.hit       = '0;
    if (!label[spmp_pkg::LABEL_W-1]) begin
      lane_out.hit[label[spmp_pkg::IDX_W-1:0]] = 1'b1;
    end
  end

endmodule

[rtl/spmp_merge.sv]
// spmp_merge: combines lane results into check flags and the next move plan
// depends on spmp_pkg
module spmp_merge (
  input  spmp_pkg::lane_out_t [spmp_pkg::SLOT_COUNT-1:0] lanes,
  output spmp_pkg::plan_t                                plan
);

  logic [spmp_pkg::SLOT_COUNT-1:0]                      seen;
  logic [spmp_pkg::SLOT_COUNT-1:0][spmp_pkg::IDX_W-1:0] pos_of;

  always_comb begin
    seen           = '0;
    pos_of         = '0;
    plan.range_err = 1'b0;
    for (int i = 0; i < spmp_pkg::SLOT_COUNT; i++) begin
      seen           = seen | lanes[i].hit;
      plan.range_err = plan.range_err | lanes[i].range_err;
      for (int l = 0; l < spmp_pkg::SLOT_COUNT; l++) begin
        if (lanes[i].hit[l]) begin
          pos_of[l] = spmp_pkg::IDX_W'(i);
        end
      end
    end
    plan.missing = (seen != {spmp_pkg::SLOT_COUNT{1'b1}});

    // lowest label not at home
    plan.found       = 1'b0;
    plan.wrong_label = '0;
    for (int i = spmp_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (!lanes[i].in_place) begin
        plan.found       = 1'b1;
        plan.wrong_label = spmp_pkg::IDX_W'(i);
      end
    end
    plan.wrong_pos = pos_of[plan.wrong_label];
    plan.src       = pos_of[plan.wrong_pos];
    plan.empty     = pos_of[0];
  end

endmodule
